// ----- hw/rtl/fifo_queue_with_cancel_assert.svh -----
// Assertion macros for the queue with cancel.
// FQC_ASSERT checks a property on the rising clock edge, and is held off
// during reset.
// FQC_NEVER checks that a condition never holds on the rising clock edge.
`ifndef FIFO_QUEUE_WITH_CANCEL_ASSERT_SVH
`define FIFO_QUEUE_WITH_CANCEL_ASSERT_SVH

`ifndef ASSERT_OFF
`define FQC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define FQC_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define FQC_ASSERT(lbl, clk, rst, prop, msg)
`define FQC_NEVER(lbl, clk, rst, cond, msg)
`endif

`endif

// ----- hw/rtl/fqc_pkg.sv -----
package fqc_pkg;

  // Queue capacity and derived widths
  localparam int DEPTH  = 16;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // Fixed field widths
  localparam int CMD_W  = 3;
  localparam int DATA_W = 32;
  localparam int ST_W   = 2;
  localparam int OCC_W  = 5;
  localparam int RM_W   = 5;

  // Command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Command codes
  localparam logic [CMD_W-1:0] CMD_ENQ    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DEQ    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_HEAD   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_LIST   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CANCEL = 3'd4;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL     = 2'd2;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd3;

  typedef enum logic [2:0] {
    OP_ENQ,
    OP_DEQ,
    OP_HEAD,
    OP_LIST,
    OP_CANCEL,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t                      op;
    logic signed [DATA_W-1:0] value;
  } fqc_cmd_t;

  // Handshake from the command queue to the back end
  typedef struct packed {
    logic     valid;
    fqc_cmd_t item;
  } fqc_qout_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_LIST,
    BK_CANCEL,
    BK_REPORT
  } bk_state_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_APPEND,
    CELL_SHIFT,
    CELL_ROTATE
  } cell_op_t;

endpackage

// ----- hw/rtl/fqc_front.sv -----
module fqc_front import fqc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cmd_valid,
  output logic                     cmd_ready,
  input  logic [CMD_W-1:0]         command,
  input  logic signed [DATA_W-1:0] value,
  output fqc_qout_t                qout,
  input  logic                     q_pop
);

  fqc_cmd_t            q_mem [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   q_count;
  logic                push;
  logic                pop;
  fqc_cmd_t            decoded;

  function automatic op_t classify(input logic [CMD_W-1:0] code);
    op_t op;
    unique case (code)
      CMD_ENQ:    op = OP_ENQ;
      CMD_DEQ:    op = OP_DEQ;
      CMD_HEAD:   op = OP_HEAD;
      CMD_LIST:   op = OP_LIST;
      CMD_CANCEL: op = OP_CANCEL;
      default:    op = OP_NOP;
    endcase
    return op;
  endfunction

  assign cmd_ready = (q_count != QCNT_W'(QDEPTH));
  assign push      = cmd_valid && cmd_ready;
  assign pop       = q_pop && (q_count != '0);

  assign decoded.op    = classify(command);
  assign decoded.value = value;

  assign qout.valid = (q_count != '0);
  assign qout.item  = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        q_count <= q_count + QCNT_W'(1);
      end else if (pop && !push) begin
        q_count <= q_count - QCNT_W'(1);
      end
    end
  end

endmodule

// ----- hw/rtl/fqc_back.sv -----
`include "fifo_queue_with_cancel_assert.svh"

module fqc_back import fqc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  fqc_qout_t                qin,
  output logic                     q_pop,
  output logic                     rsp_valid,
  input  logic                     rsp_ready,
  output logic [ST_W-1:0]          status,
  output logic signed [DATA_W-1:0] data,
  output logic [RM_W-1:0]          removed_count,
  output logic [OCC_W-1:0]         occupancy,
  output logic                     last
);

  bk_state_t                state;
  bk_state_t                state_next;
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         count_next;
  logic [CNT_W-1:0]         step;
  logic [CNT_W-1:0]         step_next;
  logic [CNT_W-1:0]         removed;
  logic [CNT_W-1:0]         removed_next;
  logic signed [DATA_W-1:0] match_value;
  logic signed [DATA_W-1:0] cells      [DEPTH];
  logic signed [DATA_W-1:0] cells_next [DEPTH];
  cell_op_t                 cell_op;
  logic                     load_match;
  logic                     out_free;
  logic                     take;
  logic                     rsp_load;
  logic [ST_W-1:0]          r_status;
  logic signed [DATA_W-1:0] r_data;
  logic [RM_W-1:0]          r_removed;
  logic                     r_last;

  assign out_free = !rsp_valid || rsp_ready;
  assign take     = (state == BK_IDLE) && qin.valid && out_free;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (take) begin
          if (qin.item.op == OP_LIST && count > CNT_W'(1)) begin
            state_next = BK_LIST;
          end else if (qin.item.op == OP_CANCEL && count != '0) begin
            state_next = BK_CANCEL;
          end
        end
      end
      BK_LIST: begin
        if (out_free && step == CNT_W'(1)) begin
          state_next = BK_IDLE;
        end
      end
      BK_CANCEL: begin
        if (step == CNT_W'(1)) begin
          state_next = BK_REPORT;
        end
      end
      BK_REPORT: begin
        if (out_free) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // Outputs and datapath control
  always_comb begin
    q_pop        = 1'b0;
    cell_op      = CELL_HOLD;
    count_next   = count;
    step_next    = step;
    removed_next = removed;
    load_match   = 1'b0;
    rsp_load     = 1'b0;
    r_status     = ST_OK;
    r_data       = '0;
    r_removed    = '0;
    r_last       = 1'b1;
    unique case (state)
      BK_IDLE: begin
        if (take) begin
          q_pop    = 1'b1;
          rsp_load = 1'b1;
          case (qin.item.op)
            OP_ENQ: begin
              if (count == CNT_W'(DEPTH)) begin
                r_status = ST_FULL;
              end else begin
                cell_op    = CELL_APPEND;
                count_next = count + CNT_W'(1);
              end
            end
            OP_DEQ: begin
              if (count == '0) begin
                r_status = ST_EMPTY;
              end else begin
                r_data     = cells[0];
                cell_op    = CELL_SHIFT;
                count_next = count - CNT_W'(1);
              end
            end
            OP_HEAD: begin
              if (count == '0) begin
                r_status = ST_EMPTY;
              end else begin
                r_data = cells[0];
              end
            end
            OP_LIST: begin
              if (count == '0) begin
                r_status = ST_EMPTY;
              end else begin
                r_data    = cells[0];
                cell_op   = CELL_ROTATE;
                r_last    = (count == CNT_W'(1));
                step_next = count - CNT_W'(1);
              end
            end
            OP_CANCEL: begin
              if (count == '0) begin
                r_status = ST_EMPTY;
              end else begin
                rsp_load     = 1'b0;
                load_match   = 1'b1;
                step_next    = count;
                removed_next = '0;
              end
            end
            default: ;
          endcase
        end
      end
      BK_LIST: begin
        if (out_free) begin
          rsp_load  = 1'b1;
          r_data    = cells[0];
          cell_op   = CELL_ROTATE;
          r_last    = (step == CNT_W'(1));
          step_next = step - CNT_W'(1);
        end
      end
      BK_CANCEL: begin
        step_next = step - CNT_W'(1);
        if (cells[0] == match_value) begin
          cell_op      = CELL_SHIFT;
          count_next   = count - CNT_W'(1);
          removed_next = removed + CNT_W'(1);
        end else begin
          cell_op = CELL_ROTATE;
        end
      end
      BK_REPORT: begin
        if (out_free) begin
          rsp_load  = 1'b1;
          r_removed = RM_W'(removed);
          r_status  = (removed != '0) ? ST_OK : ST_NOTFOUND;
        end
      end
      default: ;
    endcase
  end

  // Cell line: append at the tail, drop the head, or move the head to the tail
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cells_next[i] = cells[i];
      case (cell_op)
        CELL_APPEND: begin
          if (CNT_W'(i) == count) begin
            cells_next[i] = qin.item.value;
          end
        end
        CELL_SHIFT: begin
          if (i < DEPTH - 1) begin
            cells_next[i] = cells[(i + 1) % DEPTH];
          end
        end
        CELL_ROTATE: begin
          if (CNT_W'(i) == count - CNT_W'(1)) begin
            cells_next[i] = cells[0];
          end else if (i < DEPTH - 1) begin
            cells_next[i] = cells[(i + 1) % DEPTH];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    cells <= cells_next;
    if (load_match) begin
      match_value <= qin.item.value;
    end
    step    <= step_next;
    removed <= removed_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      status        <= r_status;
      data          <= r_data;
      removed_count <= r_removed;
      occupancy     <= OCC_W'(count_next);
      last          <= r_last;
    end
  end

  `FQC_NEVER(a_count_bound, clk, rst, count > CNT_W'(DEPTH), "entry count above capacity")
  `FQC_NEVER(a_step_live, clk, rst, (state == BK_LIST || state == BK_CANCEL) && step == '0, "pass with no step left")
  `FQC_ASSERT(a_list_keeps_count, clk, rst, (state == BK_LIST) |=> $stable(count), "list changed the entry count")
  `FQC_NEVER(a_pop_empty, clk, rst, q_pop && !qin.valid, "pop from empty command queue")

endmodule

// ----- hw/rtl/fifo_queue_with_cancel.sv -----
// Bounded FIFO of signed 32-bit words with cancel-by-value. Each command
// transaction carries a command (enqueue, dequeue, head, list, cancel) and a
// value; each yields one response transaction, except list on a non-empty
// queue, which yields one response per held entry, oldest first, with last
// set on the final one. Enqueue, dequeue, head and undefined commands are
// executed as they are taken; list emits one response per held entry as
// the response side takes them; cancel latches the match value, compares
// each held entry as the back end walks the entries through its shift
// line, dropping matches and moving the others to the tail, and then loads
// the report. A two-entry command queue sits between the decoder and the
// executing back end, so new commands are taken while a long list or
// cancel is still running. The response register holds a result until it
// is taken; the back end starts its next command in the cycle the waiting
// result is taken, or at once when none waits.
module fifo_queue_with_cancel import fqc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cmd_valid,
  output logic                     cmd_ready,
  input  logic [CMD_W-1:0]         command,
  input  logic signed [DATA_W-1:0] value,
  output logic                     rsp_valid,
  input  logic                     rsp_ready,
  output logic [ST_W-1:0]          status,
  output logic signed [DATA_W-1:0] data,
  output logic [RM_W-1:0]          removed_count,
  output logic [OCC_W-1:0]         occupancy,
  output logic                     last
);

  // Decoded commands waiting for the back end
  fqc_qout_t qout;
  logic      q_pop;

  // Front: accept and classify command transactions, hold them in the queue
  fqc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .command   (command),
    .value     (value),
    .qout      (qout),
    .q_pop     (q_pop)
  );

  // Back: hold the entries, execute commands, drive the response register
  fqc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .qin           (qout),
    .q_pop         (q_pop),
    .rsp_valid     (rsp_valid),
    .rsp_ready     (rsp_ready),
    .status        (status),
    .data          (data),
    .removed_count (removed_count),
    .occupancy     (occupancy),
    .last          (last)
  );

endmodule
